>>> hw/rtl/acks_pkg.sv
// Shared types, codes and reset values for the acknowledged bit-serial sender.
`timescale 1ns / 1ps
`default_nettype none

package acks_pkg;

    localparam int ACK_TIMEOUT_W = 9;
    localparam int RETRY_W       = 4;
    localparam int CONN_WAIT_W   = 8;
    localparam int ADDR_W        = 22;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 22;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_WAIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_ATTEMPTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTNER_ADDRESS  = 3'd4;

    localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RST      = 9'd500;
    localparam logic [RETRY_W-1:0]       MAX_RETRIES_RST      = 4'd10;
    localparam logic [CONN_WAIT_W-1:0]   CONNECT_WAIT_RST     = 8'd32;
    localparam logic [RETRY_W-1:0]       CONNECT_ATTEMPTS_RST = 4'd5;

    // phases, also reported as status
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_CONNECTING = 3'd1;
    localparam logic [2:0] PH_WANTS_BYTE = 3'd2;
    localparam logic [2:0] PH_AWAIT_ACK  = 3'd3;
    localparam logic [2:0] PH_DONE       = 3'd4;
    localparam logic [2:0] PH_CONN_FAIL  = 3'd5;
    localparam logic [2:0] PH_NO_RESP    = 3'd6;

    // input actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ACK   = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_BYTE  = 2'd3;

    // line signals
    localparam logic [1:0] SIG_NONE   = 2'd0;
    localparam logic [1:0] SIG_FIRST  = 2'd1;
    localparam logic [1:0] SIG_SECOND = 2'd2;

    localparam logic [2:0] BIT_MSB = 3'd7;

    typedef struct packed {
        logic [ACK_TIMEOUT_W-1:0] ack_timeout;
        logic [RETRY_W-1:0]       max_retries;
        logic [CONN_WAIT_W-1:0]   connect_wait;
        logic [RETRY_W-1:0]       connect_attempts;
        logic [ADDR_W-1:0]        partner_address;
    } cfg_t;

    typedef struct packed {
        logic [2:0]               phase;
        logic [7:0]               shift_byte;
        logic [2:0]               bit_pos;
        logic [ACK_TIMEOUT_W-1:0] wait_cnt;
        logic [RETRY_W-1:0]       retry_cnt;
        logic                     final_pending;
    } sender_state_t;

    typedef struct packed {
        logic [1:0]        line_signal;
        logic [ADDR_W-1:0] target_address;
        logic [2:0]        status;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/acks_cfg.sv
// Configuration register bank of the sender.
`timescale 1ns / 1ps
`default_nettype none

module acks_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [acks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [acks_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output acks_pkg::cfg_t                      cfg
);
    import acks_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_ACK_TIMEOUT:      cfg_next.ack_timeout = cfg_wdata[ACK_TIMEOUT_W-1:0];
                CFG_MAX_RETRIES:      cfg_next.max_retries = cfg_wdata[RETRY_W-1:0];
                CFG_CONNECT_WAIT:     cfg_next.connect_wait = cfg_wdata[CONN_WAIT_W-1:0];
                CFG_CONNECT_ATTEMPTS: cfg_next.connect_attempts = cfg_wdata[RETRY_W-1:0];
                CFG_PARTNER_ADDRESS:  cfg_next.partner_address = cfg_wdata[ADDR_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_timeout      <= ACK_TIMEOUT_RST;
            cfg_reg.max_retries      <= MAX_RETRIES_RST;
            cfg_reg.connect_wait     <= CONNECT_WAIT_RST;
            cfg_reg.connect_attempts <= CONNECT_ATTEMPTS_RST;
            cfg_reg.partner_address  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/acks_step.sv
// Next-state and result logic for one event beat.
`timescale 1ns / 1ps
`default_nettype none

module acks_step (
    input  wire acks_pkg::cfg_t          cfg,
    input  wire acks_pkg::sender_state_t cur,
    input  wire logic [1:0]              action,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    last_byte,
    output acks_pkg::sender_state_t      nxt,
    output acks_pkg::result_t            res
);
    import acks_pkg::*;

    logic [ACK_TIMEOUT_W-1:0] wait_inc;
    logic [RETRY_W-1:0]       retry_inc;
    logic [1:0]               sig;

    always_comb begin
        wait_inc  = cur.wait_cnt + 1'b1;
        retry_inc = cur.retry_cnt + 1'b1;
        nxt       = cur;
        sig       = SIG_NONE;
        unique case (action)
            ACT_TICK: begin
                if (cur.phase == PH_CONNECTING) begin
                    nxt.wait_cnt = wait_inc;
                    if (wait_inc >= {1'b0, cfg.connect_wait}) begin
                        if (cur.retry_cnt >= cfg.connect_attempts) begin
                            nxt.phase = PH_CONN_FAIL;
                        end else begin
                            sig           = SIG_FIRST;
                            nxt.retry_cnt = retry_inc;
                            nxt.wait_cnt  = '0;
                        end
                    end
                end else if (cur.phase == PH_AWAIT_ACK) begin
                    nxt.wait_cnt = wait_inc;
                    if (wait_inc >= cfg.ack_timeout) begin
                        nxt.retry_cnt = retry_inc;
                        nxt.wait_cnt  = '0;
                        if (retry_inc >= cfg.max_retries) begin
                            nxt.phase = PH_NO_RESP;
                        end else begin
                            sig = cur.shift_byte[cur.bit_pos] ? SIG_FIRST : SIG_SECOND;
                        end
                    end
                end
            end
            ACT_ACK: begin
                if (cur.phase == PH_CONNECTING) begin
                    nxt.phase     = PH_WANTS_BYTE;
                    nxt.wait_cnt  = '0;
                    nxt.retry_cnt = '0;
                end else if (cur.phase == PH_AWAIT_ACK) begin
                    nxt.wait_cnt  = '0;
                    nxt.retry_cnt = '0;
                    if (cur.bit_pos == 3'd0) begin
                        nxt.bit_pos = BIT_MSB;
                        nxt.phase   = cur.final_pending ? PH_DONE : PH_WANTS_BYTE;
                    end else begin
                        nxt.bit_pos = cur.bit_pos - 1'b1;
                        sig = cur.shift_byte[nxt.bit_pos] ? SIG_FIRST : SIG_SECOND;
                    end
                end
            end
            ACT_START: begin
                if (cur.phase == PH_IDLE || cur.phase >= PH_DONE) begin
                    nxt.phase         = PH_CONNECTING;
                    sig               = SIG_FIRST;
                    nxt.retry_cnt     = RETRY_W'(1);
                    nxt.wait_cnt      = '0;
                    nxt.bit_pos       = BIT_MSB;
                    nxt.final_pending = 1'b0;
                end
            end
            ACT_BYTE: begin
                if (cur.phase == PH_WANTS_BYTE) begin
                    nxt.shift_byte    = data_byte;
                    nxt.bit_pos       = BIT_MSB;
                    nxt.final_pending = last_byte;
                    nxt.wait_cnt      = '0;
                    nxt.retry_cnt     = '0;
                    nxt.phase         = PH_AWAIT_ACK;
                    sig = data_byte[BIT_MSB] ? SIG_FIRST : SIG_SECOND;
                end
            end
            default: nxt = cur;
        endcase
        res.line_signal    = sig;
        res.target_address = (sig != SIG_NONE) ? cfg.partner_address : '0;
        res.status         = nxt.phase;
    end

endmodule

`default_nettype wire

>>> hw/rtl/acked_bit_serial_sender_core.sv
// Acknowledged bit-serial sender: top level with state and result register.
//
// Usage: each input beat on s_* carries one event (tick, acknowledge, start
// or byte with its last flag). Every accepted beat yields exactly one result
// beat on m_*: the line signal to drive (none, first, second), the partner
// address that goes with it, and the status after the event.
// Latency: the result for a beat is valid the cycle after it is accepted.
// Throughput: one beat per cycle when not stalled; state and result register
// are both updated at the accepting edge by a single level of event logic.
// s_ready is high whenever the result register is empty or being drained in
// the same cycle, so a stalled receiver holds the input back after one beat.
// Reset (aresetn low, synchronous) returns the state to idle, loads the
// register defaults and empties the result register.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the next
// edge; writes to unknown indexes are dropped.
`timescale 1ns / 1ps
`default_nettype none

module acked_bit_serial_sender_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_action,
    input  wire logic [7:0]                       s_data_byte,
    input  wire logic                             s_last_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_line_signal,
    output logic [acks_pkg::ADDR_W-1:0]           m_target_address,
    output logic [2:0]                            m_status,
    input  wire logic                             cfg_we,
    input  wire logic [acks_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [acks_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import acks_pkg::*;

    cfg_t          cfg;
    sender_state_t state_reg;
    sender_state_t state_next;
    result_t       res_next;
    result_t       res_reg;
    logic          m_valid_reg;
    logic          accept;

    acks_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    acks_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .action    (s_action),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .nxt       (state_next),
        .res       (res_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_IDLE;
            state_reg.shift_byte    <= '0;
            state_reg.bit_pos       <= BIT_MSB;
            state_reg.wait_cnt      <= '0;
            state_reg.retry_cnt     <= '0;
            state_reg.final_pending <= 1'b0;
            m_valid_reg             <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_line_signal    = res_reg.line_signal;
    assign m_target_address = res_reg.target_address;
    assign m_status         = res_reg.status;

endmodule

`default_nettype wire

>>> hw/rtl/acks_checker.sv
// Port-level checks for the sender core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module acks_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [1:0]                     m_line_signal,
    input wire logic [acks_pkg::ADDR_W-1:0]    m_target_address,
    input wire logic [2:0]                     m_status
);
    import acks_pkg::*;

    // a held result beat must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_signal)
            && $stable(m_target_address) && $stable(m_status))
        else $error("result beat changed while stalled");

    // no address goes out without a signal
    a_addr_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_signal == SIG_NONE |-> m_target_address == '0)
        else $error("address driven with no line signal");

    // a zero bit is only sent while a bit is outstanding
    a_second_sig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_signal == SIG_SECOND |-> m_status == PH_AWAIT_ACK)
        else $error("zero bit sent outside awaiting ack");

    // a first signal is a connect request or a one bit
    a_first_sig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_signal == SIG_FIRST
            |-> m_status == PH_CONNECTING || m_status == PH_AWAIT_ACK)
        else $error("first signal sent in wrong phase");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind acked_bit_serial_sender_core acks_checker u_acks_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_line_signal    (m_line_signal),
    .m_target_address (m_target_address),
    .m_status         (m_status)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the acknowledged bit-serial sender core.
`timescale 1ns / 1ps

module tb_top;
    import acks_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_action = ACT_TICK;
    logic [7:0]            s_data_byte = 8'd0;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_line_signal;
    logic [ADDR_W-1:0]     m_target_address;
    logic [2:0]            m_status;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ACK_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    acked_bit_serial_sender_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_signal    (m_line_signal),
        .m_target_address (m_target_address),
        .m_status         (m_status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // expected sender state and register copies
    logic [2:0]               exp_phase;
    logic [7:0]               exp_shift;
    logic [2:0]               exp_bitpos;
    logic [ACK_TIMEOUT_W-1:0] exp_wait;
    logic [RETRY_W-1:0]       exp_tries;
    logic                     exp_final;
    logic [ACK_TIMEOUT_W-1:0] reg_ack_timeout;
    logic [RETRY_W-1:0]       reg_max_retries;
    logic [CONN_WAIT_W-1:0]   reg_connect_wait;
    logic [RETRY_W-1:0]       reg_connect_attempts;
    logic [ADDR_W-1:0]        reg_partner;

    result_t pending_results[$];
    result_t seen_res;
    result_t due_res;

    int   errors = 0;
    int   events_sent = 0;
    int   results_checked = 0;
    int   settings_applied = 0;
    int   quiet = 0;
    int   stall_left = 0;
    bit   idle_en = 1'b1;
    bit   stall_en = 1'b1;
    logic [7:0] status_seen = '0;

    function automatic logic [1:0] bit_signal();
        return exp_shift[exp_bitpos] ? SIG_FIRST : SIG_SECOND;
    endfunction

    // advance the expected state by one event and return the line result
    function automatic result_t next_line_result(input logic [1:0] act, input logic [7:0] data,
                                                 input logic last);
        result_t r;
        logic [1:0] sig;
        sig = SIG_NONE;
        case (act)
            ACT_TICK: begin
                if (exp_phase == PH_CONNECTING) begin
                    exp_wait = exp_wait + 1'b1;
                    if (exp_wait >= reg_connect_wait) begin
                        if (exp_tries >= reg_connect_attempts) begin
                            exp_phase = PH_CONN_FAIL;
                        end else begin
                            sig = SIG_FIRST;
                            exp_tries = exp_tries + 1'b1;
                            exp_wait = '0;
                        end
                    end
                end else if (exp_phase == PH_AWAIT_ACK) begin
                    exp_wait = exp_wait + 1'b1;
                    if (exp_wait >= reg_ack_timeout) begin
                        exp_tries = exp_tries + 1'b1;
                        exp_wait = '0;
                        if (exp_tries >= reg_max_retries) exp_phase = PH_NO_RESP;
                        else sig = bit_signal();
                    end
                end
            end
            ACT_ACK: begin
                if (exp_phase == PH_CONNECTING) begin
                    exp_phase = PH_WANTS_BYTE;
                    exp_wait = '0;
                    exp_tries = '0;
                end else if (exp_phase == PH_AWAIT_ACK) begin
                    exp_wait = '0;
                    exp_tries = '0;
                    if (exp_bitpos == 3'd0) begin
                        exp_bitpos = BIT_MSB;
                        exp_phase = exp_final ? PH_DONE : PH_WANTS_BYTE;
                    end else begin
                        exp_bitpos = exp_bitpos - 1'b1;
                        sig = bit_signal();
                    end
                end
            end
            ACT_START: begin
                if (exp_phase == PH_IDLE || exp_phase >= PH_DONE) begin
                    exp_phase = PH_CONNECTING;
                    sig = SIG_FIRST;
                    exp_tries = 4'd1;
                    exp_wait = '0;
                    exp_bitpos = BIT_MSB;
                    exp_final = 1'b0;
                end
            end
            default: begin
                if (exp_phase == PH_WANTS_BYTE) begin
                    exp_shift = data;
                    exp_bitpos = BIT_MSB;
                    exp_final = last;
                    exp_wait = '0;
                    exp_tries = '0;
                    exp_phase = PH_AWAIT_ACK;
                    sig = bit_signal();
                end
            end
        endcase
        r.line_signal = sig;
        r.target_address = (sig != SIG_NONE) ? reg_partner : '0;
        r.status = exp_phase;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endtask

    // one input beat; valid stays up after acceptance unless the next call idles
    task automatic send_event(input logic [1:0] act, input logic [7:0] data, input logic last);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_data_byte <= data;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(next_line_result(act, data, last));
        events_sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_ACK_TIMEOUT:      reg_ack_timeout      = val[ACK_TIMEOUT_W-1:0];
            CFG_MAX_RETRIES:      reg_max_retries      = val[RETRY_W-1:0];
            CFG_CONNECT_WAIT:     reg_connect_wait     = val[CONN_WAIT_W-1:0];
            CFG_CONNECT_ATTEMPTS: reg_connect_attempts = val[RETRY_W-1:0];
            CFG_PARTNER_ADDRESS:  reg_partner          = val[ADDR_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // unused upper data bits are filled with noise; they must be dropped
    task automatic apply_setting(input logic [ACK_TIMEOUT_W-1:0] at, input logic [RETRY_W-1:0] mr,
                                 input logic [CONN_WAIT_W-1:0] cw, input logic [RETRY_W-1:0] ca,
                                 input logic [ADDR_W-1:0] addr);
        logic [CFG_DATA_W-1:0] val;
        quiesce();
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
        val = CFG_DATA_W'($urandom);
        val[ACK_TIMEOUT_W-1:0] = at;
        write_reg(CFG_ACK_TIMEOUT, val);
        val = CFG_DATA_W'($urandom);
        val[RETRY_W-1:0] = mr;
        write_reg(CFG_MAX_RETRIES, val);
        val = CFG_DATA_W'($urandom);
        val[CONN_WAIT_W-1:0] = cw;
        write_reg(CFG_CONNECT_WAIT, val);
        val = CFG_DATA_W'($urandom);
        val[RETRY_W-1:0] = ca;
        write_reg(CFG_CONNECT_ATTEMPTS, val);
        write_reg(CFG_PARTNER_ADDRESS, addr);
        settings_applied++;
    endtask

    // mostly the event the current phase is waiting for, with some noise
    task automatic run_random(input int count, input int tick_pct);
        int r;
        logic [1:0] act;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                act = 2'($urandom_range(0, 3));
            end else begin
                case (exp_phase)
                    PH_CONNECTING, PH_AWAIT_ACK: act = (r < 8 + tick_pct) ? ACT_TICK : ACT_ACK;
                    PH_WANTS_BYTE:               act = ACT_BYTE;
                    default:                     act = ACT_START;
                endcase
            end
            send_event(act, 8'($urandom), ($urandom_range(0, 5) == 0));
        end
    endtask

    task automatic test_events_at_defaults();
        send_event(ACT_ACK, 8'h00, 1'b0);      // stray ack in idle
        send_event(ACT_TICK, 8'h00, 1'b0);
        send_event(ACT_BYTE, 8'h00, 1'b1);     // byte before connect
        send_event(ACT_START, 8'h00, 1'b0);
        send_event(ACT_START, 8'hFF, 1'b1);    // busy, ignored
        send_event(ACT_ACK, 8'h00, 1'b0);
        send_event(ACT_TICK, 8'h00, 1'b0);     // nothing to time out
        send_event(ACT_ACK, 8'h00, 1'b0);      // stray in wants byte
        send_event(ACT_START, 8'h00, 1'b0);
        send_event(ACT_BYTE, 8'hFF, 1'b1);
        repeat (8) send_event(ACT_ACK, 8'h00, 1'b0);
        send_event(ACT_ACK, 8'h00, 1'b0);      // stray in done
        send_event(ACT_BYTE, 8'hA5, 1'b0);
    endtask

    task automatic test_zero_registers();
        apply_setting('0, '0, '0, '0, {ADDR_W{1'b1}});
        send_event(ACT_START, 8'h00, 1'b0);
        send_event(ACT_TICK, 8'h00, 1'b0);     // fails on first wait
        send_event(ACT_START, 8'h00, 1'b0);
        send_event(ACT_ACK, 8'h00, 1'b0);
        send_event(ACT_BYTE, 8'h00, 1'b0);
        send_event(ACT_TICK, 8'h00, 1'b0);     // no response on first timeout
    endtask

    task automatic test_small_windows();
        apply_setting(9'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
                      8'($urandom_range(1, 4)), 4'($urandom_range(1, 4)), 22'($urandom));
        run_random(400, 30);
    endtask

    task automatic test_full_range_registers();
        apply_setting(9'($urandom_range(1, 511)), 4'($urandom_range(1, 15)),
                      8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)), 22'($urandom));
        run_random(300, 40);
    endtask

    task automatic test_min_registers();
        apply_setting(9'd1, 4'd1, 8'd1, 4'd1, '0);
        run_random(250, 25);
    endtask

    task automatic test_max_registers();
        apply_setting(9'd511, 4'd15, 8'd255, 4'd15, {ADDR_W{1'b1}});
        run_random(200, 30);
    endtask

    task automatic test_timeout_storm();
        apply_setting(9'd3, 4'd4, 8'd3, 4'd3, 22'($urandom));
        run_random(300, 85);
    endtask

    task automatic test_back_to_back();
        apply_setting(9'($urandom_range(1, 3)), 4'($urandom_range(1, 3)),
                      8'($urandom_range(1, 3)), 4'($urandom_range(1, 3)), 22'($urandom));
        idle_en  = 1'b0;
        stall_en = 1'b0;
        run_random(300, 35);
    endtask

    // receiver stalls in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_res = {m_line_signal, m_target_address, m_status};
            status_seen[m_status] = 1'b1;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected result sig=%0d addr=%h status=%0d",
                                     seen_res.line_signal, seen_res.target_address,
                                     seen_res.status));
            end else begin
                due_res = pending_results.pop_front();
                if (seen_res.line_signal !== due_res.line_signal ||
                    seen_res.target_address !== due_res.target_address ||
                    seen_res.status !== due_res.status) begin
                    flag_error($sformatf({"result %0d: expected sig=%0d addr=%h status=%0d, ",
                                          "got sig=%0d addr=%h status=%0d"}, results_checked,
                                         due_res.line_signal, due_res.target_address,
                                         due_res.status, seen_res.line_signal,
                                         seen_res.target_address, seen_res.status));
                end
            end
            results_checked++;
        end
    end

    // ends a run that stops making progress on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet++;
        end
    end

    initial begin
        exp_phase            = PH_IDLE;
        exp_shift            = '0;
        exp_bitpos           = BIT_MSB;
        exp_wait             = '0;
        exp_tries            = '0;
        exp_final            = 1'b0;
        reg_ack_timeout      = ACK_TIMEOUT_RST;
        reg_max_retries      = MAX_RETRIES_RST;
        reg_connect_wait     = CONNECT_WAIT_RST;
        reg_connect_attempts = CONNECT_ATTEMPTS_RST;
        reg_partner          = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_events_at_defaults();
        test_zero_registers();
        test_small_windows();
        test_full_range_registers();
        test_min_registers();
        test_max_registers();
        test_timeout_storm();
        test_back_to_back();
        quiesce();
        repeat (4) @(posedge aclk);

        $display("Sent %0d events, checked %0d results over %0d register settings.",
                 events_sent, results_checked, settings_applied);
        $display("Status codes observed (bit per code): %b, mismatches: %0d",
                 status_seen, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/acks_pkg.sv
hw/rtl/acks_cfg.sv
hw/rtl/acks_step.sv
hw/rtl/acked_bit_serial_sender_core.sv
hw/rtl/acks_checker.sv
tb/sv/tb_top.sv
